>>> src/sdpf_pkg.sv
// Shared constants and types of the soft-disk pair force pipeline.
package sdpf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;
  localparam int QW         = CW + FRAC_BITS;
  localparam int UW         = CW + FRAC_BITS + 1;
  localparam int FIFO_DEPTH = 4;

  localparam logic [1:0] REG_BOX_X    = 2'd0;
  localparam logic [1:0] REG_BOX_Y    = 2'd1;
  localparam logic [1:0] REG_DIAMETER = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  localparam logic [CW-1:0] BOX_RESET = CW'(100 << FRAC_BITS);
  localparam logic [CW-1:0] ONE_FIX   = CW'(1 << FRAC_BITS);

  typedef struct packed {
    logic [CW-1:0] box_len_x;
    logic [CW-1:0] box_len_y;
    logic [CW-1:0] diameter;
    logic [CW-1:0] strength;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic          nx;
    logic          ny;
    logic          hit;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [2*CW-1:0] r2;
  } pair_t;

endpackage

>>> src/soft_disk_pair_force.sv
// Top level of the soft-disk pair force pipeline with its configuration registers.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   first_x, first_y, second_x, second_y
//  m_axis    out  m_axis_tvalid/m_axis_tready   force_x, force_y; tuser in_range, saturated
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled; an item passes through the
//  32-step remainder chain of the wrap, the 32-step square root and the
//  48-step restoring divider, one bit per stage each.
//  Reset clears all valid state; configuration returns to box 100.0, diameter 1.0, strength 1.0.
//  A stalled output freezes the back end; the four-entry queue lets the front keep taking
//  items until it fills.
module soft_disk_pair_force (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  logic [4*sdpf_pkg::CW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // force_x, force_y
  output logic [2*sdpf_pkg::CW-1:0]   m_axis_tdata,
  // in_range, saturated
  output logic [1:0]                  m_axis_tuser,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [sdpf_pkg::CW-1:0]     cfg_data_i
);
  import sdpf_pkg::*;

  cfg_t  cfg_q;
  pair_t f_pair, q_pair;
  logic  push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_len_x <= BOX_RESET;
      cfg_q.box_len_y <= BOX_RESET;
      cfg_q.diameter  <= ONE_FIX;
      cfg_q.strength  <= ONE_FIX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_X:    cfg_q.box_len_x <= cfg_data_i;
        REG_BOX_Y:    cfg_q.box_len_y <= cfg_data_i;
        REG_DIAMETER: cfg_q.diameter  <= cfg_data_i;
        REG_STRENGTH: cfg_q.strength  <= cfg_data_i;
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  sdpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .pair_o     (f_pair),
    .full_i     (full)
  );

  sdpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (f_pair),
    .pop_i   (pop),
    .dout_o  (q_pair),
    .full_o  (full),
    .empty_o (empty)
  );

  sdpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pair_i      (q_pair),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

>>> src/sdpf_front.sv
// Front end: minimum-image wrap, squares and range classification.
module sdpf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdpf_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [4*sdpf_pkg::CW-1:0]  in_data_i,
  output logic                       push_o,
  output sdpf_pkg::pair_t            pair_o,
  input  logic                       full_i
);
  import sdpf_pkg::*;

  localparam int RS = CW;

  logic              en;
  logic [RS:0]       c_vld_q;
  logic [CW-1:0]     c_px_q [RS+1];
  logic [CW-1:0]     c_mx_q [RS+1];
  logic [CW-1:0]     c_ox_q [RS+1];
  logic [CW-1:0]     c_py_q [RS+1];
  logic [CW-1:0]     c_my_q [RS+1];
  logic [CW-1:0]     c_oy_q [RS+1];
  logic [RS:0]       c_nx_q;
  logic [RS:0]       c_ny_q;
  logic              w_vld_q, s_vld_q;
  logic [CW-1:0]     w_ax_q, w_ay_q, s_ax_q, s_ay_q;
  logic              w_nx_q, w_ny_q, s_nx_q, s_ny_q;
  logic [2*CW-1:0]   s_x2_q, s_y2_q, d2_q;
  logic [CW-1:0]     fx, fy, sx, sy, magx, magy;
  logic              ltx, lty;
  logic [2*CW:0]     r2;

  function automatic logic [2*CW-1:0] rem_step(input logic [CW-1:0] p, input logic [CW-1:0] m,
                                               input logic [CW-1:0] len);
    logic [CW:0] t;
    t = {p, m[CW-1]};
    if (t >= {1'b0, len}) t = t - {1'b0, len};
    return {t[CW-1:0], m[CW-2:0], 1'b0};
  endfunction

  function automatic logic [CW:0] wrap(input logic [CW-1:0] rem, input logic [CW-1:0] orig,
                                       input logic [CW-1:0] len, input logic n);
    logic [CW-1:0] mg;
    logic          ng;
    if (len == '0) begin
      mg = orig;
      ng = n;
    end else if ({rem, 1'b0} >= {1'b0, len}) begin
      mg = len - rem;
      ng = !n;
    end else begin
      mg = rem;
      ng = n;
    end
    return {(mg != '0) && ng, mg};
  endfunction

  assign fx   = in_data_i[CW-1:0];
  assign fy   = in_data_i[2*CW-1:CW];
  assign sx   = in_data_i[3*CW-1:2*CW];
  assign sy   = in_data_i[4*CW-1:3*CW];
  assign ltx  = fx < sx;
  assign lty  = fy < sy;
  assign magx = ltx ? sx - fx : fx - sx;
  assign magy = lty ? sy - fy : fy - sy;

  assign en         = !s_vld_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = s_vld_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= '0;
      w_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= {c_vld_q[RS-1:0], in_valid_i};
      w_vld_q <= c_vld_q[RS];
      s_vld_q <= w_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q <= cfg_i.diameter * cfg_i.diameter;
    if (en) begin
      c_px_q[0] <= '0;
      c_mx_q[0] <= magx;
      c_ox_q[0] <= magx;
      c_nx_q[0] <= ltx;
      c_py_q[0] <= '0;
      c_my_q[0] <= magy;
      c_oy_q[0] <= magy;
      c_ny_q[0] <= lty;
      for (int k = 1; k <= RS; k++) begin
        {c_px_q[k], c_mx_q[k]} <= rem_step(c_px_q[k-1], c_mx_q[k-1], cfg_i.box_len_x);
        {c_py_q[k], c_my_q[k]} <= rem_step(c_py_q[k-1], c_my_q[k-1], cfg_i.box_len_y);
        c_ox_q[k] <= c_ox_q[k-1];
        c_oy_q[k] <= c_oy_q[k-1];
        c_nx_q[k] <= c_nx_q[k-1];
        c_ny_q[k] <= c_ny_q[k-1];
      end
      {w_nx_q, w_ax_q} <= wrap(c_px_q[RS], c_ox_q[RS], cfg_i.box_len_x, c_nx_q[RS]);
      {w_ny_q, w_ay_q} <= wrap(c_py_q[RS], c_oy_q[RS], cfg_i.box_len_y, c_ny_q[RS]);
      s_x2_q <= w_ax_q * w_ax_q;
      s_y2_q <= w_ay_q * w_ay_q;
      s_ax_q <= w_ax_q;
      s_ay_q <= w_ay_q;
      s_nx_q <= w_nx_q;
      s_ny_q <= w_ny_q;
    end
  end

  assign r2 = {1'b0, s_x2_q} + {1'b0, s_y2_q};

  always_comb begin
    pair_o.side.ax  = s_ax_q;
    pair_o.side.ay  = s_ay_q;
    pair_o.side.nx  = s_nx_q;
    pair_o.side.ny  = s_ny_q;
    pair_o.side.hit = (r2 != '0) && (r2 < {1'b0, d2_q});
    pair_o.r2       = r2[2*CW-1:0];
  end

endmodule

>>> src/sdpf_fifo.sv
// Short queue between the front end and the force back end.
module sdpf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdpf_pkg::pair_t din_i,
  input  logic            pop_i,
  output sdpf_pkg::pair_t dout_o,
  output logic            full_o,
  output logic            empty_o
);
  import sdpf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  pair_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + (PW+1)'($past(push_i)) - (PW+1)'($past(pop_i)))
    else $error("queue count mismatch");

endmodule

>>> src/sdpf_back.sv
// Back end: square root, reciprocal scaling, force products and saturation.
module sdpf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sdpf_pkg::cfg_t            cfg_i,
  input  sdpf_pkg::pair_t           pair_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2*sdpf_pkg::CW-1:0] out_data_o,
  output logic [1:0]                out_user_o
);
  import sdpf_pkg::*;

  localparam int SQ = CW;
  localparam int DV = QW;
  localparam int RW = CW + 3;
  localparam int MW = 2*CW + 2;

  logic              en;
  logic [SQ:0]       q_vld_q;
  logic [RW-1:0]     q_rem_q  [SQ+1];
  logic [CW-1:0]     q_root_q [SQ+1];
  logic [2*CW-1:0]   q_v_q    [SQ+1];
  side_t             q_side_q [SQ+1];
  logic [DV:0]       d_vld_q;
  logic [CW-1:0]     d_p_q    [DV+1];
  logic [QW-1:0]     d_nq_q   [DV+1];
  logic [CW-1:0]     d_r_q    [DV+1];
  side_t             d_side_q [DV+1];
  logic              m1_vld_q, u_vld_q, m2_vld_q, o_vld_q;
  logic [2*CW-1:0]   m1_ph_q;
  logic [CW+FRAC_BITS-1:0] m1_pl_q;
  logic [UW-1:0]     u_q;
  logic [2*CW:0]     m2_hx_q, m2_hy_q;
  logic [CW+FRAC_BITS-1:0] m2_lx_q, m2_ly_q;
  side_t             m1_side_q, u_side_q, m2_side_q;
  logic [CW-1:0]     o_fx_q, o_fy_q;
  logic              o_hit_q, o_sat_q;
  logic [2*CW:0]     usum;
  logic [MW-1:0]     mx, my;
  logic [CW:0]       rx, ry;

  function automatic logic [RW+3*CW-1:0] sqrt_step(input logic [RW-1:0] rem,
                                                   input logic [CW-1:0] root,
                                                   input logic [2*CW-1:0] v);
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    logic [CW-1:0] rt;
    r2    = {rem[CW:0], v[2*CW-1:2*CW-2]};
    trial = {1'b0, root, 2'b01};
    if (r2 >= trial) begin
      r2 = r2 - trial;
      rt = {root[CW-2:0], 1'b1};
    end else begin
      rt = {root[CW-2:0], 1'b0};
    end
    return {r2, rt, v[2*CW-3:0], 2'b00};
  endfunction

  function automatic logic [CW+QW-1:0] div_step(input logic [CW-1:0] p, input logic [QW-1:0] nq,
                                                input logic [CW-1:0] d);
    logic [CW:0] t;
    logic        qb;
    t  = {p, nq[QW-1]};
    qb = 1'b0;
    if (t >= {1'b0, d}) begin
      t  = t - {1'b0, d};
      qb = 1'b1;
    end
    return {t[CW-1:0], nq[QW-2:0], qb};
  endfunction

  function automatic logic [CW:0] clip(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0] lim_p;
    logic [MW-1:0] lim_n;
    lim_p = '0;
    lim_p[CW-2:0] = '1;
    lim_n = '0;
    lim_n[CW-1] = 1'b1;
    if (!neg) begin
      if (m > lim_p) return {1'b1, lim_p[CW-1:0]};
      return {1'b0, m[CW-1:0]};
    end
    if (m > lim_n) return {1'b1, lim_n[CW-1:0]};
    return {1'b0, CW'(0) - m[CW-1:0]};
  endfunction

  assign en          = !o_vld_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = o_vld_q;
  assign out_data_o  = {o_fy_q, o_fx_q};
  assign out_user_o  = {o_sat_q, o_hit_q};

  assign usum = {1'b0, m1_ph_q} + (2*CW+1)'(m1_pl_q >> FRAC_BITS);
  assign mx   = {1'b0, m2_hx_q} + MW'(m2_lx_q >> FRAC_BITS);
  assign my   = {1'b0, m2_hy_q} + MW'(m2_ly_q >> FRAC_BITS);
  assign rx   = clip(mx, m2_side_q.nx);
  assign ry   = clip(my, m2_side_q.ny);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q  <= '0;
      d_vld_q  <= '0;
      m1_vld_q <= 1'b0;
      u_vld_q  <= 1'b0;
      m2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en) begin
      q_vld_q  <= {q_vld_q[SQ-1:0], pop_o};
      d_vld_q  <= {d_vld_q[DV-1:0], q_vld_q[SQ]};
      m1_vld_q <= d_vld_q[DV];
      u_vld_q  <= m1_vld_q;
      m2_vld_q <= u_vld_q;
      o_vld_q  <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_rem_q[0]  <= '0;
      q_root_q[0] <= '0;
      q_v_q[0]    <= pair_i.r2;
      q_side_q[0] <= pair_i.side;
      for (int k = 1; k <= SQ; k++) begin
        {q_rem_q[k], q_root_q[k], q_v_q[k]} <= sqrt_step(q_rem_q[k-1], q_root_q[k-1],
                                                         q_v_q[k-1]);
        q_side_q[k] <= q_side_q[k-1];
      end
      d_p_q[0]    <= '0;
      d_nq_q[0]   <= {cfg_i.diameter - q_root_q[SQ], {FRAC_BITS{1'b0}}};
      d_r_q[0]    <= q_root_q[SQ];
      d_side_q[0] <= q_side_q[SQ];
      for (int k = 1; k <= DV; k++) begin
        {d_p_q[k], d_nq_q[k]} <= div_step(d_p_q[k-1], d_nq_q[k-1], d_r_q[k-1]);
        d_r_q[k]    <= d_r_q[k-1];
        d_side_q[k] <= d_side_q[k-1];
      end
      m1_ph_q   <= cfg_i.strength * d_nq_q[DV][QW-1:FRAC_BITS];
      m1_pl_q   <= cfg_i.strength * d_nq_q[DV][FRAC_BITS-1:0];
      m1_side_q <= d_side_q[DV];
      if (usum > (2*CW+1)'(1) << (CW+FRAC_BITS)) begin
        u_q <= UW'(1) << (CW+FRAC_BITS);
      end else begin
        u_q <= usum[UW-1:0];
      end
      u_side_q  <= m1_side_q;
      m2_hx_q   <= u_q[UW-1:FRAC_BITS] * u_side_q.ax;
      m2_hy_q   <= u_q[UW-1:FRAC_BITS] * u_side_q.ay;
      m2_lx_q   <= u_q[FRAC_BITS-1:0] * u_side_q.ax;
      m2_ly_q   <= u_q[FRAC_BITS-1:0] * u_side_q.ay;
      m2_side_q <= u_side_q;
      if (m2_side_q.hit) begin
        o_fx_q  <= rx[CW-1:0];
        o_fy_q  <= ry[CW-1:0];
        o_hit_q <= 1'b1;
        o_sat_q <= rx[CW] || ry[CW];
      end else begin
        o_fx_q  <= '0;
        o_fy_q  <= '0;
        o_hit_q <= 1'b0;
        o_sat_q <= 1'b0;
      end
    end
  end

endmodule

>>> dv/soft_disk_pair_force_tb.sv
// Testbench for soft_disk_pair_force: random and directed pairs, checked against a built-in predictor.
`timescale 1ns / 1ps

class force_board;
  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic        in_range;
    logic        sat;
  } force_t;

  bit [63:0] box_x, box_y, dia, str;
  force_t    force_q[$];
  int        errors;

  function new();
    box_x = 64'd6553600;
    box_y = 64'd6553600;
    dia   = 64'd65536;
    str   = 64'd65536;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      sdpf_pkg::REG_BOX_X:    box_x = val;
      sdpf_pkg::REG_BOX_Y:    box_y = val;
      sdpf_pkg::REG_DIAMETER: dia   = val;
      sdpf_pkg::REG_STRENGTH: str   = val;
    endcase
  endfunction

  function bit [63:0] min_image(bit [63:0] a, bit [63:0] b, bit [63:0] len, output bit neg);
    bit        n;
    bit [63:0] mag, q, ql;
    n   = a < b;
    mag = n ? b - a : a - b;
    if (len != 0) begin
      q  = (2 * mag + len) / (2 * len);
      ql = q * len;
      if (ql > mag) begin
        mag = ql - mag;
        n   = !n;
      end else begin
        mag = mag - ql;
      end
    end
    neg = (mag != 0) && n;
    return mag;
  endfunction

  function bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function logic [31:0] scale(bit [63:0] u, bit [63:0] mag, bit neg, inout logic sat);
    bit [63:0] m;
    m = (u >> 16) * mag + (((u & 64'hFFFF) * mag) >> 16);
    if (!neg) begin
      if (m > 64'h7FFFFFFF) begin
        sat = 1'b1;
        return 32'h7FFFFFFF;
      end
      return m[31:0];
    end
    if (m > 64'h80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return 32'(64'd0 - m);
  endfunction

  function void note_pair(logic [127:0] d);
    force_t    f;
    bit        nx, ny;
    bit [63:0] ax, ay, x2, r2, cap, r, g, gh, gl, u;
    ax  = min_image(d[31:0], d[95:64], box_x, nx);
    ay  = min_image(d[63:32], d[127:96], box_y, ny);
    x2  = ax * ax;
    r2  = x2 + ay * ay;
    f   = '{32'd0, 32'd0, 1'b0, 1'b0};
    if (!(r2 < x2 || r2 == 0 || r2 >= dia * dia)) begin
      cap = 64'd1 << 48;
      r   = root_floor(r2);
      g   = ((dia - r) << 16) / r;
      gh  = g >> 16;
      gl  = g & 64'hFFFF;
      if (gh != 0 && str > cap / gh) begin
        u = cap;
      end else begin
        u = str * gh + ((str * gl) >> 16);
        if (u > cap) u = cap;
      end
      f.fx       = scale(u, ax, nx, f.sat);
      f.fy       = scale(u, ay, ny, f.sat);
      f.in_range = 1'b1;
    end
    force_q.push_back(f);
  endfunction

  function void check_force(logic [63:0] data, logic [1:0] user);
    force_t f;
    if (force_q.size() == 0) begin
      $error("unexpected item: tdata %h tuser %b", data, user);
      errors++;
      return;
    end
    f = force_q.pop_front();
    if (data[31:0] !== f.fx) begin
      $error("force_x: expected %h, actual %h", f.fx, data[31:0]);
      errors++;
    end
    if (data[63:32] !== f.fy) begin
      $error("force_y: expected %h, actual %h", f.fy, data[63:32]);
      errors++;
    end
    if (user[0] !== f.in_range) begin
      $error("in_range: expected %b, actual %b", f.in_range, user[0]);
      errors++;
    end
    if (user[1] !== f.sat) begin
      $error("saturated: expected %b, actual %b", f.sat, user[1]);
      errors++;
    end
  endfunction
endclass

module soft_disk_pair_force_tb;
  localparam int LIMIT = 1_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = sdpf_pkg::REG_BOX_X;
  logic [31:0]  cfg_data_i = '0;

  force_board board = new();
  int         idle_mode = 0;
  int         cycles = 0;

  soft_disk_pair_force uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("soft_disk_pair_force_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_force(m_axis_tdata, m_axis_tuser);
    if (idle_mode == 2) m_axis_tready <= $urandom_range(99) >= 58;
    else if (idle_mode == 3) m_axis_tready <= $urandom_range(99) >= 15;
    else m_axis_tready <= 1'b1;
  end

  task automatic send_pair(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx, logic [31:0] sy);
    logic [127:0] d;
    d = {sy, sx, fy, fx};
    while ((idle_mode == 1 && $urandom_range(99) < 58) ||
           (idle_mode == 3 && $urandom_range(99) < 15)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_pair(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.force_q.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [31:0] bx, logic [31:0] by, logic [31:0] dm, logic [31:0] st);
    logic [31:0] vals[4];
    vals = '{bx, by, dm, st};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      board.set_reg(2'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] near_to(logic [31:0] a, bit [63:0] box, bit [63:0] dm);
    bit [63:0] span, off, p;
    span = dm + dm / 4 + 2;
    if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
    off = {$urandom, $urandom} % (2 * span + 1);
    p   = 64'(a) + box * 4 + off - span;
    return 32'(p % box);
  endfunction

  task automatic random_pair();
    logic [31:0] fx, fy;
    if ($urandom_range(99) < 25) begin
      send_pair($urandom, $urandom, $urandom, $urandom);
    end else begin
      fx = 32'({$urandom, $urandom} % board.box_x);
      fy = 32'({$urandom, $urandom} % board.box_y);
      send_pair(fx, fy, near_to(fx, board.box_x, board.dia),
                near_to(fy, board.box_y, board.dia));
    end
  endtask

  initial begin
    logic [31:0] cfgs[7][4];
    cfgs = '{
      '{32'd6553600, 32'd6553600, 32'd65536, 32'd65536},
      '{32'd65536, 32'd65536, 32'd131072, 32'd0},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
      '{32'd655360, 32'd196608, 32'd1, 32'd98304},
      '{32'd0, 32'd0, 32'd0, 32'd0},
      '{32'd3276800, 32'd3276800, 32'd1310720, 32'hFFFFFFFF},
      '{32'hFFFFFFFF, 32'd65536, 32'd65536, 32'd65536}};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs at reset settings: box 100, diameter 1, strength 1
    send_pair(32'd0, 32'd0, 32'd0, 32'd0);
    send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0);
    send_pair(32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pair(32'd32768, 32'd0, 32'd0, 32'd0);
    send_pair(32'd0, 32'd0, 32'd32768, 32'd0);
    send_pair(32'd0, 32'd1000, 32'd0, 32'd0);
    send_pair(32'd1, 32'd0, 32'd0, 32'd0);
    send_pair(32'd0, 32'd0, 32'd0, 32'd1);
    send_pair(32'd0, 32'd0, 32'd3276800, 32'd0);
    send_pair(32'd0, 32'd0, 32'd0, 32'd3276800);
    send_pair(32'd6553600, 32'd100, 32'd0, 32'd0);
    send_pair(32'd13107210, 32'd6553590, 32'd0, 32'd0);
    send_pair(32'd6553500, 32'd6553500, 32'd100, 32'd100);
    send_pair(32'd45000, 32'd45000, 32'd0, 32'd0);
    send_pair(32'd65535, 32'd0, 32'd0, 32'd0);
    send_pair(32'd65536, 32'd0, 32'd0, 32'd0);
    send_pair(32'd20000, 32'd30000, 32'd40000, 32'd1000);
    send_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFF00);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 4) begin
        cfgs[4][0] = $urandom_range(32'd65536, 32'd65536000);
        cfgs[4][1] = $urandom_range(32'd65536, 32'd65536000);
        cfgs[4][2] = $urandom_range(32'd1, 32'd524288);
        cfgs[4][3] = $urandom;
      end
      load_regs(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      for (int k = 0; k < 100; k++) begin
        idle_mode = (k / 25 + ph) % 4;
        random_pair();
      end
      drain();
    end

    idle_mode = 0;
    if (board.errors == 0 && board.force_q.size() == 0)
      $display("soft_disk_pair_force_tb: done, clean");
    else
      $display("soft_disk_pair_force_tb: done, errors");
    $finish;
  end
endmodule

>>> soft_disk_pair_force.f
src/sdpf_pkg.sv
src/sdpf_front.sv
src/sdpf_fifo.sv
src/sdpf_back.sv
src/soft_disk_pair_force.sv
dv/soft_disk_pair_force_tb.sv
